[design/pkv_pkg.sv]
package pkv_pkg;

   // default sizes
   localparam int NUM_PAGES_DEFAULT     = 64;
   localparam int MAX_SEQUENCES_DEFAULT = 16;

   // fixed field widths
   localparam int PAGE_W      = 6;
   localparam int FREE_CNT_W  = 7;
   localparam int SEQ_CNT_W   = 5;
   localparam int TAG_W       = 16;
   localparam int LEN_W       = 16;
   localparam int PSIZE_W     = 13;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int MAXP_W      = 7;
   localparam int DIVIDEND_W  = LEN_W + 1;
   localparam logic [PSIZE_W-1:0] PAGE_SIZE_RESET = 13'd16;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAGES = 1'b1;

   // status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SHORT   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_UNKNOWN = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_DIV,
      ST_DECIDE,
      ST_RECL_RD,
      ST_RECL_WR,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_POP_SETUP,
      ST_POP_RD,
      ST_POP_WR,
      ST_DONE
   } state_type;

endpackage

[design/paged_kv_cache_page_allocator.sv]
// channel   ports                                          handshake
// req       start, busy, req_operation/seq_id/seq_len      start & !busy
// rsp       rsp_valid, rsp_page ... rsp_seq_count          rsp_valid, one cycle
// csr       csr_valid, csr_ready, csr_index, csr_data      csr_valid & csr_ready
//
// one request at a time: the page-count divide and lookup, then, for each reclaimed,
// freed or granted page, one memory read state and one write state.
// writing max_pages starts a fill of all NUM_PAGES free-queue entries; busy is high
// and csr_ready low meanwhile. csr_ready is also low while start is high.
// reset leaves the queue empty and needs no fill.
// results are emitted one per strobe and cannot be stalled.
module paged_kv_cache_page_allocator #(
   parameter int NUM_PAGES     = pkv_pkg::NUM_PAGES_DEFAULT,
   parameter int MAX_SEQUENCES = pkv_pkg::MAX_SEQUENCES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_operation,
   input  logic [pkv_pkg::TAG_W-1:0]       req_seq_id,
   input  logic [pkv_pkg::LEN_W-1:0]       req_seq_len,
   output logic                            rsp_valid,
   output logic [pkv_pkg::PAGE_W-1:0]      rsp_page,
   output logic                            rsp_page_valid,
   output logic                            rsp_last,
   output logic [1:0]                      rsp_status,
   output logic [pkv_pkg::FREE_CNT_W-1:0]  rsp_free_count,
   output logic [pkv_pkg::SEQ_CNT_W-1:0]   rsp_seq_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pkv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pkv_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pkv_pkg::*;

   localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int CW = $clog2(NUM_PAGES + 1);
   localparam int EW = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
   localparam int SW = $clog2(MAX_SEQUENCES + 1);
   localparam int AW = EW + PW;

   state_type state_ff, state_in;

   logic [PSIZE_W-1:0]    page_size_ff, page_size_in;
   logic [PW-1:0]         head_ff, head_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [CW-1:0]         final_ff, final_in;
   logic [SW-1:0]         live_ff, live_in;
   logic [MAX_SEQUENCES-1:0] valid_ff, valid_in;
   logic [TAG_W-1:0]      tag_ff [MAX_SEQUENCES];
   logic [CW-1:0]         cnt_ff [MAX_SEQUENCES];
   logic                  op_ff;
   logic [TAG_W-1:0]      seq_ff;
   logic [EW-1:0]         ent_ff, ent_in;
   logic [CW-1:0]         idx_ff, idx_in;
   status_type            status_ff, status_in;
   logic [DIVIDEND_W-1:0] need_ff, need_in;

   // memories
   logic [PW-1:0] queue_mem [NUM_PAGES];
   logic [PW-1:0] pages_mem [MAX_SEQUENCES * NUM_PAGES];
   logic [PW-1:0] q_rdata_ff, p_rdata_ff;
   logic          q_we, p_we;
   logic [PW-1:0] q_waddr, q_wdata, q_raddr, p_wdata;
   logic [AW-1:0] p_waddr, p_raddr;

   // table updates
   logic          tab_we;
   logic [CW-1:0] tab_cnt;

   // result word
   logic          emit;
   logic [PW-1:0] emit_page;
   logic          emit_pvalid, emit_last;
   status_type    emit_status;
   logic [CW-1:0] emit_free;
   logic          rsp_valid_ff, rsp_pvalid_ff, rsp_last_ff;
   logic [PW-1:0] rsp_page_ff;
   status_type    rsp_status_ff;
   logic [CW-1:0] rsp_free_ff;
   logic [SW-1:0] rsp_seq_ff;

   // divider
   logic                  div_start, div_done;
   logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
   logic [PSIZE_W-1:0]    eff_ps;

   // lookup
   logic          hit, has_free;
   logic [EW-1:0] hit_idx, free_idx;

   logic          accept, csr_we;
   logic [CW-1:0] max_sat;
   logic [PW-1:0] head_dec, head_inc, back_pos;
   logic [CW:0]   back_sum;
   logic          need_short;

   assign accept = start && (state_ff == ST_IDLE);
   assign csr_we = csr_valid && csr_ready;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;

   // divide setup: ceil(len / ps) as (len + ps - 1) / ps
   assign eff_ps       = (page_size_ff == '0) ? PSIZE_W'(1) : page_size_ff;
   assign div_dividend = DIVIDEND_W'(req_seq_len) + DIVIDEND_W'(eff_ps)
                         - DIVIDEND_W'(1);
   assign div_start    = accept;

   pkv_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (eff_ps),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // lowest matching entry and lowest empty entry
   always_comb begin
      hit      = 1'b0;
      has_free = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int e = MAX_SEQUENCES - 1; e >= 0; e--) begin
         if (valid_ff[e] && tag_ff[e] == seq_ff) begin
            hit     = 1'b1;
            hit_idx = EW'(e);
         end
         if (!valid_ff[e]) begin
            has_free = 1'b1;
            free_idx = EW'(e);
         end
      end
   end

   // queue pointer arithmetic
   assign head_dec = (head_ff == '0) ? PW'(NUM_PAGES - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == PW'(NUM_PAGES - 1)) ? '0 : head_ff + 1'b1;
   assign back_sum = (CW + 1)'(head_ff) + (CW + 1)'(total_ff);
   assign back_pos = (back_sum >= (CW + 1)'(NUM_PAGES)) ?
                     PW'(back_sum - (CW + 1)'(NUM_PAGES)) : PW'(back_sum);
   assign need_short = (32'(need_ff) > 32'(total_ff));
   assign max_sat = (32'(csr_data[MAXP_W-1:0]) > NUM_PAGES) ?
                    CW'(NUM_PAGES) : CW'(csr_data[MAXP_W-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_we && csr_index == CSR_MAX_PAGES) state_in = ST_FILL;
            else if (accept) state_in = ST_DIV;
         end
         ST_FILL: begin
            if (idx_ff == CW'(NUM_PAGES - 1)) state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (op_ff == OP_FREE) begin
               state_in = hit ? ST_FREE_RD : ST_DONE;
            end else if (need_short || (!hit && !has_free)) begin
               state_in = ST_DONE;
            end else begin
               state_in = hit ? ST_RECL_RD : ST_POP_SETUP;
            end
         end
         ST_RECL_RD: state_in = (idx_ff == cnt_ff[ent_ff]) ? ST_POP_SETUP : ST_RECL_WR;
         ST_RECL_WR: state_in = ST_RECL_RD;
         ST_FREE_RD: state_in = (idx_ff == cnt_ff[ent_ff]) ? ST_DONE : ST_FREE_WR;
         ST_FREE_WR: state_in = ST_FREE_RD;
         ST_POP_SETUP: state_in = (need_ff == '0) ? ST_DONE : ST_POP_RD;
         ST_POP_RD: state_in = ST_POP_WR;
         ST_POP_WR: begin
            if (DIVIDEND_W'(idx_ff) + DIVIDEND_W'(1) == need_ff) state_in = ST_IDLE;
            else state_in = ST_POP_RD;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      page_size_in = page_size_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      final_in     = final_ff;
      live_in      = live_ff;
      valid_in     = valid_ff;
      ent_in       = ent_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      need_in      = need_ff;
      q_we         = 1'b0;
      q_waddr      = '0;
      q_wdata      = '0;
      q_raddr      = head_ff;
      p_we         = 1'b0;
      p_waddr      = '0;
      p_wdata      = q_rdata_ff;
      p_raddr      = {ent_ff, idx_ff[PW-1:0]};
      tab_we       = 1'b0;
      tab_cnt      = '0;
      emit         = 1'b0;
      emit_page    = '0;
      emit_pvalid  = 1'b0;
      emit_last    = 1'b1;
      emit_status  = status_ff;
      emit_free    = total_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_we && csr_index == CSR_PAGE_SIZE) begin
               page_size_in = csr_data[PSIZE_W-1:0];
            end else if (csr_we) begin
               head_in  = '0;
               total_in = max_sat;
               live_in  = '0;
               valid_in = '0;
               idx_in   = '0;
            end
         end
         ST_FILL: begin
            q_we    = 1'b1;
            q_waddr = idx_ff[PW-1:0];
            q_wdata = idx_ff[PW-1:0];
            idx_in  = idx_ff + 1'b1;
         end
         ST_DIV: begin
            need_in = div_quotient;
         end
         ST_DECIDE: begin
            idx_in    = '0;
            status_in = STATUS_OK;
            if (op_ff == OP_FREE) begin
               ent_in = hit_idx;
               if (!hit) status_in = STATUS_UNKNOWN;
            end else if (need_short) begin
               status_in = STATUS_SHORT;
            end else if (!hit && !has_free) begin
               status_in = STATUS_FULL;
            end else if (hit) begin
               ent_in = hit_idx;
            end else begin
               ent_in             = free_idx;
               valid_in[free_idx] = 1'b1;
               live_in            = live_ff + 1'b1;
            end
         end
         ST_RECL_RD, ST_FREE_RD: begin
            if (state_ff == ST_FREE_RD && idx_ff == cnt_ff[ent_ff]) begin
               valid_in[ent_ff] = 1'b0;
               tab_we           = 1'b1;
               if (live_ff != '0) live_in = live_ff - 1'b1;
            end
         end
         ST_RECL_WR: begin
            if (32'(total_ff) < NUM_PAGES) begin
               head_in  = head_dec;
               total_in = total_ff + 1'b1;
               q_we     = 1'b1;
               q_waddr  = head_dec;
               q_wdata  = p_rdata_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         ST_FREE_WR: begin
            if (32'(total_ff) < NUM_PAGES) begin
               total_in = total_ff + 1'b1;
               q_we     = 1'b1;
               q_waddr  = back_pos;
               q_wdata  = p_rdata_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         ST_POP_SETUP: begin
            tab_we   = 1'b1;
            tab_cnt  = CW'(need_ff);
            final_in = total_ff - CW'(need_ff);
            idx_in   = '0;
         end
         ST_POP_RD: begin
            q_raddr = head_ff;
         end
         ST_POP_WR: begin
            p_we        = 1'b1;
            p_waddr     = {ent_ff, idx_ff[PW-1:0]};
            head_in     = head_inc;
            total_in    = total_ff - 1'b1;
            idx_in      = idx_ff + 1'b1;
            emit        = 1'b1;
            emit_page   = q_rdata_ff;
            emit_pvalid = 1'b1;
            emit_last   = (DIVIDEND_W'(idx_ff) + DIVIDEND_W'(1) == need_ff);
            emit_status = STATUS_OK;
            emit_free   = final_ff;
         end
         ST_DONE: begin
            emit = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // memories with registered read data
   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_waddr] <= q_wdata;
      q_rdata_ff <= queue_mem[q_raddr];
      if (p_we) pages_mem[p_waddr] <= p_wdata;
      p_rdata_ff <= pages_mem[p_raddr];
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_size_ff <= PAGE_SIZE_RESET;
         head_ff      <= '0;
         total_ff     <= '0;
         live_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         page_size_ff <= page_size_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         live_ff      <= live_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= emit;
      end
      final_ff  <= final_in;
      ent_ff    <= ent_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      need_ff   <= need_in;
      if (accept) begin
         op_ff  <= req_operation;
         seq_ff <= req_seq_id;
      end
      if (state_ff == ST_DECIDE && op_ff == OP_ALLOC && !need_short && !hit && has_free)
         tag_ff[free_idx] <= seq_ff;
      if (tab_we) cnt_ff[ent_ff] <= tab_cnt;
      rsp_page_ff   <= emit_page;
      rsp_pvalid_ff <= emit_pvalid;
      rsp_last_ff   <= emit_last;
      rsp_status_ff <= emit_status;
      rsp_free_ff   <= emit_free;
      rsp_seq_ff    <= live_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_page       = PAGE_W'(rsp_page_ff);
   assign rsp_page_valid = rsp_pvalid_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_count = FREE_CNT_W'(rsp_free_ff);
   assign rsp_seq_count  = SEQ_CNT_W'(rsp_seq_ff);

endmodule

[design/pkv_divider.sv]
module pkv_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pkv_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [pkv_pkg::PSIZE_W-1:0]     divisor,
   output logic                            done,
   output logic [pkv_pkg::DIVIDEND_W-1:0]  quotient
);
   import pkv_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [PSIZE_W:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [PSIZE_W-1:0]    dsr_ff, dsr_in;
   logic [PSIZE_W:0]      trial;

   // one restoring step per cycle, msb first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff[PSIZE_W-1:0], quo_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
